@@ hw/rtl/h3fp_pkg.sv @@
// Package with shared types, status codes and frame type helpers for the HTTP/3 frame parser.
`default_nettype none

package h3fp_pkg;

    localparam int unsigned VAL_W = 62;
    localparam int unsigned LEN_CFG_W = 32;
    localparam logic [LEN_CFG_W-1:0] MAX_KEPT_RESET = 32'd65536;

    localparam logic [2:0] ST_CONTINUE  = 3'd0;
    localparam logic [2:0] ST_DATA      = 3'd1;
    localparam logic [2:0] ST_KEPT      = 3'd2;
    localparam logic [2:0] ST_SKIPPED   = 3'd3;
    localparam logic [2:0] ST_RESERVED  = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    localparam logic [VAL_W-1:0] FT_DATA            = 62'h0;
    localparam logic [VAL_W-1:0] FT_HEADERS         = 62'h1;
    localparam logic [VAL_W-1:0] FT_H2_PRIORITY     = 62'h2;
    localparam logic [VAL_W-1:0] FT_CANCEL_PUSH     = 62'h3;
    localparam logic [VAL_W-1:0] FT_SETTINGS        = 62'h4;
    localparam logic [VAL_W-1:0] FT_PUSH_PROMISE    = 62'h5;
    localparam logic [VAL_W-1:0] FT_H2_PING         = 62'h6;
    localparam logic [VAL_W-1:0] FT_GOAWAY          = 62'h7;
    localparam logic [VAL_W-1:0] FT_H2_WINDOW       = 62'h8;
    localparam logic [VAL_W-1:0] FT_H2_CONTINUATION = 62'h9;
    localparam logic [VAL_W-1:0] FT_MAX_PUSH_ID     = 62'hd;
    localparam logic [VAL_W-1:0] FT_PRIO_UPDATE_REQ = 62'hf0700;
    localparam logic [VAL_W-1:0] FT_PRIO_UPDATE_PSH = 62'hf0701;

    typedef enum logic [3:0] {
        STG_TYPE    = 4'b0001,
        STG_LENGTH  = 4'b0010,
        STG_PAYLOAD = 4'b0100,
        STG_SKIP    = 4'b1000
    } stage_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             byte_valid;
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic [VAL_W-1:0] frame_kind;
        logic [VAL_W-1:0] frame_size;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t rec;
    } q_wr_t;

    typedef struct packed {
        logic    avail;
        result_t rec;
    } q_rd_t;

    function automatic logic is_kept(input logic [VAL_W-1:0] t);
        return (t == FT_HEADERS) || (t == FT_CANCEL_PUSH) || (t == FT_SETTINGS) ||
               (t == FT_PUSH_PROMISE) || (t == FT_GOAWAY) || (t == FT_MAX_PUSH_ID) ||
               (t == FT_PRIO_UPDATE_REQ) || (t == FT_PRIO_UPDATE_PSH);
    endfunction

    function automatic logic is_reserved_h2(input logic [VAL_W-1:0] t);
        return (t == FT_H2_PRIORITY) || (t == FT_H2_PING) || (t == FT_H2_WINDOW) ||
               (t == FT_H2_CONTINUATION);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/http3_frame_stream_parser_top.sv @@
// Top level of the HTTP/3 frame stream parser.
//
// The s_ channel takes one stream byte per transaction. For every accepted byte the block
// returns exactly one result transaction on the m_ channel, in order: the status and
// byte-valid flag in m_tuser, the payload byte and the current frame type and length in
// m_tdata, and m_tlast on the byte that completes a frame.
// The cfg channel writes the largest allowed kept control frame length; it is always ready.
// The user must write it only while the block is idle; the block itself does not enforce this.
// An accepted byte's result is written into a small queue and then into the output register
// that drives m_tvalid. The block takes one byte per cycle while the queue is not full; the
// parser front end decodes each byte combinationally as it is accepted.
// Reset (aresetn low, synchronous) returns the parser to the frame type stage, clears any
// latched error and sets the length limit to 65536.
// When the receiver stalls, the output register holds its result, the queue fills, and
// s_tready drops once the queue is full; no byte is lost.
`default_nettype none

module http3_frame_stream_parser_top
    import h3fp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // [7:0] payload_byte, [69:8] frame_kind,
                                         // [131:70] frame_size, [135:132] zero
    output logic [3:0]        m_tuser,   // [2:0] status, [3] byte_valid
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    q_wr_t   q_wr;
    q_rd_t   q_rd;
    logic    q_full;
    logic    pop;
    logic    fire;
    result_t out_rec;

    assign s_tready  = !q_full;
    assign fire      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    h3fp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (s_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .q_wr      (q_wr)
    );

    h3fp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .full    (q_full),
        .q_rd    (q_rd)
    );

    h3fp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd      (q_rd),
        .out_ready (m_tready),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_rec   (out_rec)
    );

    assign m_tdata = {4'd0, out_rec.frame_size, out_rec.frame_kind, out_rec.payload_byte};
    assign m_tuser = {out_rec.byte_valid, out_rec.status};
    assign m_tlast = out_rec.frame_end;

endmodule

`default_nettype wire

@@ hw/rtl/h3fp_front.sv @@
// Front end: accepts stream bytes, decodes varints and frame state, and emits one result per byte.
`default_nettype none

module h3fp_front
    import h3fp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 cfg_fire,
    input  wire logic [LEN_CFG_W-1:0] cfg_value,
    output q_wr_t                     q_wr
);

    stage_t            stage_reg, stage_next;
    logic [VAL_W-1:0]  vval_reg, vval_next;
    logic [3:0]        vneed_reg, vneed_next;
    logic [3:0]        vcnt_reg, vcnt_next;
    logic [VAL_W-1:0]  type_reg, type_next;
    logic [VAL_W-1:0]  len_reg, len_next;
    logic [VAL_W-1:0]  left_reg, left_next;
    logic [2:0]        err_reg, err_next;
    logic [LEN_CFG_W-1:0] max_reg;

    logic              first;
    logic [3:0]        need;
    logic [3:0]        cnt_inc;
    logic [VAL_W-1:0]  val;
    logic              done;
    logic              keep;
    logic [VAL_W-1:0]  left_dec;
    result_t           rec;

    always_comb begin
        first    = (vcnt_reg == 4'd0);
        need     = first ? (4'd1 << in_byte[7:6]) : vneed_reg;
        val      = first ? {{(VAL_W-6){1'b0}}, in_byte[5:0]} : {vval_reg[VAL_W-9:0], in_byte};
        cnt_inc  = vcnt_reg + 4'd1;
        done     = (cnt_inc >= need);
        keep     = is_kept(type_reg);
        left_dec = left_reg - {{(VAL_W-1){1'b0}}, (left_reg != '0)};

        stage_next = stage_reg;
        vval_next  = vval_reg;
        vneed_next = vneed_reg;
        vcnt_next  = vcnt_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        rec        = '0;
        rec.status = ST_CONTINUE;

        if (err_reg != ST_CONTINUE) begin
            rec.status = err_reg;
        end else begin
            if (stage_reg == STG_TYPE || stage_reg == STG_LENGTH) begin
                if (done) begin
                    vval_next  = '0;
                    vneed_next = 4'd0;
                    vcnt_next  = 4'd0;
                end else begin
                    vval_next  = val;
                    vneed_next = need;
                    vcnt_next  = cnt_inc;
                end
            end
            unique case (stage_reg)
                STG_TYPE: begin
                    if (done) begin
                        type_next = val;
                        len_next  = '0;
                        if (is_reserved_h2(val)) begin
                            err_next   = ST_RESERVED;
                            rec.status = ST_RESERVED;
                        end else begin
                            stage_next = STG_LENGTH;
                        end
                    end
                end
                STG_LENGTH: begin
                    if (done) begin
                        len_next  = val;
                        left_next = val;
                        if (keep && (val > {{(VAL_W-LEN_CFG_W){1'b0}}, max_reg})) begin
                            err_next   = ST_TOO_LARGE;
                            rec.status = ST_TOO_LARGE;
                        end else if (val == '0) begin
                            stage_next    = STG_TYPE;
                            rec.frame_end = 1'b1;
                            rec.status    = (type_reg == FT_DATA) ? ST_DATA :
                                            (keep ? ST_KEPT : ST_SKIPPED);
                        end else begin
                            stage_next = (keep || type_reg == FT_DATA) ? STG_PAYLOAD : STG_SKIP;
                        end
                    end
                end
                STG_PAYLOAD: begin
                    left_next        = left_dec;
                    rec.byte_valid   = 1'b1;
                    rec.payload_byte = in_byte;
                    rec.status       = (type_reg == FT_DATA) ? ST_DATA : ST_KEPT;
                    if (left_dec == '0) begin
                        rec.frame_end = 1'b1;
                        stage_next    = STG_TYPE;
                    end
                end
                STG_SKIP: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        rec.status    = ST_SKIPPED;
                        rec.frame_end = 1'b1;
                        stage_next    = STG_TYPE;
                    end
                end
                default: begin
                    stage_next = STG_TYPE;
                end
            endcase
        end

        rec.frame_kind = type_next;
        rec.frame_size = len_next;
        q_wr.push      = fire;
        q_wr.rec       = rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STG_TYPE;
            vval_reg  <= '0;
            vneed_reg <= 4'd0;
            vcnt_reg  <= 4'd0;
            type_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            err_reg   <= ST_CONTINUE;
        end else if (fire) begin
            stage_reg <= stage_next;
            vval_reg  <= vval_next;
            vneed_reg <= vneed_next;
            vcnt_reg  <= vcnt_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_KEPT_RESET;
        end else if (cfg_fire) begin
            max_reg <= cfg_value;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/h3fp_queue.sv @@
// Short result queue between the parser front end and the output stage.
`default_nettype none

module h3fp_queue
    import h3fp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire q_wr_t q_wr,
    input  wire logic  pop,
    output logic       full,
    output q_rd_t      q_rd
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t           slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        full        = (cnt_reg == FULL_CNT);
        do_push     = q_wr.push && !full;
        do_pop      = pop && (cnt_reg != '0);
        wr_ptr_next = do_push ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        q_rd.avail  = (cnt_reg != '0);
        q_rd.rec    = slots[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= q_wr.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/h3fp_back.sv @@
// Output stage: takes results from the queue and holds them in the output register until taken.
`default_nettype none

module h3fp_back
    import h3fp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire q_rd_t q_rd,
    input  wire logic  out_ready,
    output logic       pop,
    output logic       out_valid,
    output result_t    out_rec
);

    logic    valid_reg, valid_next;
    result_t rec_reg;

    always_comb begin
        pop        = q_rd.avail && (!valid_reg || out_ready);
        valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        out_valid  = valid_reg;
        out_rec    = rec_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= q_rd.rec;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/h3fp_checker.sv @@
// Port-level checker for the HTTP/3 frame parser and its bind to the top level.
`default_nettype none

module h3fp_checker
    import h3fp_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [3:0]   m_tuser,
    input wire logic         m_tlast
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output transaction changed.");

    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser[2:0] == ST_DATA || m_tuser[2:0] == ST_KEPT ||
                                 m_tuser[2:0] == ST_SKIPPED))
        else $error("Frame end with a status that cannot end a frame.");

    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == ST_DATA || m_tuser[2:0] == ST_KEPT))
        else $error("Payload byte outside a passed frame.");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> (m_tdata[7:0] == 8'd0))
        else $error("Nonzero payload byte without byte valid.");

endmodule

bind http3_frame_stream_parser_top h3fp_checker u_h3fp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb_http3_frame_stream_parser_top.sv @@
// Self-checking testbench for the HTTP/3 frame stream parser with a built-in frame predictor.
`default_nettype none

module tb_http3_frame_stream_parser_top
    import h3fp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 305;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        logic [2:0] status;
        logic       byte_valid;
        logic       frame_end;
    } probe_row_t;

    localparam probe_row_t PROBES [25] = '{
        '{8'h00, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h00, 1'b1, ST_DATA,     1'b0, 1'b1},
        '{8'h01, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h02, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_KEPT,     1'b1, 1'b0},
        '{8'h00, 1'b1, ST_KEPT,     1'b1, 1'b1},
        '{8'h40, 1'b0, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h21, 1'b0, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h80, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h00, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h00, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h02, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'haa, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h55, 1'b1, ST_SKIPPED,  1'b0, 1'b1},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'hff, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h00, 1'b1, ST_SKIPPED,  1'b0, 1'b1},
        '{8'h04, 1'b1, ST_CONTINUE, 1'b0, 1'b0},
        '{8'h00, 1'b1, ST_KEPT,     1'b0, 1'b1}
    };

    localparam logic [VAL_W-1:0] KEPT_TYPES [8] = '{
        FT_HEADERS, FT_CANCEL_PUSH, FT_SETTINGS, FT_PUSH_PROMISE,
        FT_GOAWAY, FT_MAX_PUSH_ID, FT_PRIO_UPDATE_REQ, FT_PRIO_UPDATE_PSH
    };

    localparam logic [VAL_W-1:0] H2_TYPES [4] = '{
        FT_H2_PRIORITY, FT_H2_PING, FT_H2_WINDOW, FT_H2_CONTINUATION
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    // Predictor state.
    logic [LEN_CFG_W-1:0] len_limit;
    stage_t               prs_stage;
    logic [VAL_W-1:0]     vi_acc;
    logic [3:0]           vi_needed;
    logic [3:0]           vi_count;
    logic [VAL_W-1:0]     cur_type;
    logic [VAL_W-1:0]     cur_len;
    logic [VAL_W-1:0]     left_bytes;
    logic [2:0]           err_code;

    result_t    expect_q[$];
    logic [7:0] frame_bytes[$];
    probe_row_t cur_fix;
    int         bytes_sent;
    int         bytes_in;
    int         idle_cycles;
    int         err_count;
    int         calm_left;

    http3_frame_stream_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic kept_type(input logic [VAL_W-1:0] t);
        case (t)
            FT_HEADERS, FT_CANCEL_PUSH, FT_SETTINGS, FT_PUSH_PROMISE, FT_GOAWAY,
            FT_MAX_PUSH_ID, FT_PRIO_UPDATE_REQ, FT_PRIO_UPDATE_PSH: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic h2_type(input logic [VAL_W-1:0] t);
        case (t)
            FT_H2_PRIORITY, FT_H2_PING, FT_H2_WINDOW, FT_H2_CONTINUATION: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic varint_collect(input logic [7:0] b, output logic [VAL_W-1:0] v);
        v = '0;
        if (vi_count == 4'd0) begin
            vi_needed = 4'd1 << b[7:6];
            vi_acc = {{(VAL_W-6){1'b0}}, b[5:0]};
        end else begin
            vi_acc = {vi_acc[VAL_W-9:0], b};
        end
        vi_count = vi_count + 4'd1;
        if (vi_count >= vi_needed) begin
            v = vi_acc;
            vi_count = '0;
            vi_needed = '0;
            vi_acc = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t          r;
        logic [VAL_W-1:0] v;
        logic             keep;
        r = '0;
        r.status = ST_CONTINUE;
        if (err_code != ST_CONTINUE) begin
            r.status = err_code;
        end else if (prs_stage == STG_TYPE) begin
            if (varint_collect(b, v)) begin
                cur_type = v;
                cur_len = '0;
                if (h2_type(v)) begin
                    err_code = ST_RESERVED;
                    r.status = ST_RESERVED;
                end else begin
                    prs_stage = STG_LENGTH;
                end
            end
        end else if (prs_stage == STG_LENGTH) begin
            if (varint_collect(b, v)) begin
                keep = kept_type(cur_type);
                cur_len = v;
                left_bytes = v;
                if (keep && v > {{(VAL_W-LEN_CFG_W){1'b0}}, len_limit}) begin
                    err_code = ST_TOO_LARGE;
                    r.status = ST_TOO_LARGE;
                end else if (v == '0) begin
                    prs_stage = STG_TYPE;
                    r.frame_end = 1'b1;
                    r.status = (cur_type == FT_DATA) ? ST_DATA : (keep ? ST_KEPT : ST_SKIPPED);
                end else begin
                    prs_stage = (keep || cur_type == FT_DATA) ? STG_PAYLOAD : STG_SKIP;
                end
            end
        end else begin
            if (left_bytes != '0) left_bytes = left_bytes - 1'b1;
            if (prs_stage == STG_PAYLOAD) begin
                r.byte_valid = 1'b1;
                r.payload_byte = b;
                r.status = (cur_type == FT_DATA) ? ST_DATA : ST_KEPT;
                if (left_bytes == '0) begin
                    r.frame_end = 1'b1;
                    prs_stage = STG_TYPE;
                end
            end else if (left_bytes == '0) begin
                r.status = ST_SKIPPED;
                r.frame_end = 1'b1;
                prs_stage = STG_TYPE;
            end
        end
        r.frame_kind = cur_type;
        r.frame_size = cur_len;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        logic    progress;
        if (!aresetn) begin
            len_limit = MAX_KEPT_RESET;
            prs_stage = STG_TYPE;
            vi_acc = '0;
            vi_needed = '0;
            vi_count = '0;
            cur_type = '0;
            cur_len = '0;
            left_bytes = '0;
            err_code = ST_CONTINUE;
            idle_cycles = 0;
        end else begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready) begin
                len_limit = cfg_data;
                progress = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                want = parse_byte(s_tdata);
                if (cur_fix.typed) begin
                    want.status = cur_fix.status;
                    want.byte_valid = cur_fix.byte_valid;
                    want.payload_byte = cur_fix.byte_valid ? s_tdata : 8'h00;
                    want.frame_end = cur_fix.frame_end;
                end
                expect_q.push_back(want);
                bytes_in++;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                progress = 1'b1;
                got.status = m_tuser[2:0];
                got.byte_valid = m_tuser[3];
                got.payload_byte = m_tdata[7:0];
                got.frame_end = m_tlast;
                got.frame_kind = m_tdata[69:8];
                got.frame_size = m_tdata[131:70];
                if (expect_q.size() == 0) begin
                    $error("Result transaction with no expected result pending");
                    err_count++;
                end else begin
                    want = expect_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("frame_end", want.frame_end, got.frame_end);
                    check_field("frame_kind", want.frame_kind, got.frame_kind);
                    check_field("frame_size", want.frame_size, got.frame_size);
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : receiver
        int   run;
        int   roll;
        logic held;
        held = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && bytes_in >= 300) begin
                // Hold off long enough for the internal queue to fill and stall the input.
                held = 1'b1;
                m_tready = 1'b0;
                run = 200;
            end else begin
                roll = $urandom_range(99);
                if (roll < 15) begin
                    m_tready = 1'b1;
                    run = $urandom_range(150, 40);
                end else if (roll < 55) begin
                    m_tready = 1'b1;
                    run = $urandom_range(6, 1);
                end else if (roll < 95) begin
                    m_tready = 1'b0;
                    run = $urandom_range(3, 1);
                end else begin
                    m_tready = 1'b0;
                    run = $urandom_range(40, 10);
                end
            end
            repeat (run - 1) @(negedge aclk);
        end
    end

    function automatic int next_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            calm_left = $urandom_range(120, 30);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic push_byte(input logic [7:0] b, input probe_row_t fix);
        int gap;
        gap = next_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        cur_fix = fix;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Appends a varint, sometimes in a wider encoding than the value needs.
    function automatic void put_varint(input logic [VAL_W-1:0] v);
        int         code;
        int         n;
        logic [7:0] bt;
        logic [VAL_W-1:0] sh;
        code = 0;
        while (code < 3 && (v >> (8 * (1 << code) - 2)) != '0) code++;
        if ($urandom_range(3) == 0) code = $urandom_range(3, code);
        n = 1 << code;
        for (int i = n - 1; i >= 0; i--) begin
            sh = v >> (8 * i);
            bt = sh[7:0];
            if (i == n - 1) bt[7:6] = code[1:0];
            frame_bytes.push_back(bt);
        end
    endfunction

    function automatic logic [VAL_W-1:0] unknown_type(input int max_shift);
        logic [VAL_W-1:0] t;
        do begin
            t = VAL_W'({$urandom, $urandom});
            t = t >> $urandom_range(max_shift);
        end while (kept_type(t) || h2_type(t) || t == FT_DATA);
        return t;
    endfunction

    task automatic send_header();
        while (frame_bytes.size() != 0) push_byte(frame_bytes.pop_front(), '0);
    endtask

    task automatic send_frame();
        logic [VAL_W-1:0] ftype;
        logic [VAL_W-1:0] flen;
        int               roll;
        int               cap;
        logic [7:0]       pb;
        roll = $urandom_range(99);
        if (roll < 35) begin
            ftype = FT_DATA;
            flen = ($urandom_range(9) == 0) ? $urandom_range(200, 13) : $urandom_range(12);
        end else if (roll < 75) begin
            ftype = KEPT_TYPES[$urandom_range(7)];
            cap = (len_limit < 16) ? int'(len_limit) : 16;
            flen = $urandom_range(cap);
            if (len_limit <= 64 && $urandom_range(6) == 0) flen = len_limit;
        end else begin
            ftype = (roll < 90) ? unknown_type(VAL_W - 1) : unknown_type(0);
            flen = $urandom_range(10);
        end
        put_varint(ftype);
        put_varint(flen);
        send_header();
        for (int i = 0; i < int'(flen); i++) begin
            roll = $urandom_range(19);
            pb = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hff : 8'($urandom_range(255));
            push_byte(pb, '0);
        end
    endtask

    task automatic run_phase(input int target);
        while (bytes_sent < target) send_frame();
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expect_q.size() != 0) @(negedge aclk);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_fix = '0;
        bytes_sent = 0;
        bytes_in = 0;
        idle_cycles = 0;
        err_count = 0;
        calm_left = 0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (PROBES[i]) push_byte(PROBES[i].in_byte, PROBES[i]);

        run_phase(bytes_sent + PHASE_BYTES);
        write_limit(32'd0);
        run_phase(bytes_sent + PHASE_BYTES);
        write_limit(32'hffff_ffff);
        run_phase(bytes_sent + PHASE_BYTES);
        write_limit($urandom_range(20, 1));
        run_phase(bytes_sent + PHASE_BYTES);
        write_limit($urandom);
        run_phase(bytes_sent + PHASE_BYTES);

        // Close with one sticky error, chosen at random, and a few bytes after it.
        if ($urandom_range(1) == 0) begin
            put_varint(H2_TYPES[$urandom_range(3)]);
        end else begin
            put_varint(KEPT_TYPES[$urandom_range(7)]);
            put_varint({{(VAL_W-LEN_CFG_W){1'b0}}, len_limit} + 1'b1);
        end
        repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
        send_header();

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expect_q.size() != 0) begin
            $error("%0d expected results never arrived", expect_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
